[hdl/mrml_pkg.sv]
// ----------------------------------------------------------------------------
// Memory region metadata locator package
// Shared widths, payload layouts, status codes and controller interface types.
// ----------------------------------------------------------------------------
package mrml_pkg;

    localparam int ADDR_W      = 52;
    localparam int LIMIT_W     = 23;
    localparam int IDX_W       = 6;
    localparam int CNT_W       = 7;
    localparam int GB_SHIFT    = 30;
    localparam int BLOCK_W     = ADDR_W - GB_SHIFT;
    // 512 2 MB entries and 262144 4 KB entries cover one 1 GB block.
    localparam int SUB_2M_SHIFT = 9;
    localparam int SUB_4K_SHIFT = 18;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_NO_REGION   = 2'd1,
        ST_BLOCK_RANGE = 2'd2,
        ST_NOT_INIT    = 2'd3
    } status_t;

    // Input beat payload, first field in the lowest bits.
    typedef struct packed {
        logic [6:0]         pad;
        logic [ADDR_W-1:0]  phys_addr;
        logic [LIMIT_W-1:0] block_limit;
        logic [ADDR_W-1:0]  meta_4k_base;
        logic [ADDR_W-1:0]  meta_2m_base;
        logic [ADDR_W-1:0]  meta_1g_base;
        logic [ADDR_W-1:0]  region_init_end;
        logic [ADDR_W-1:0]  region_size;
        logic [ADDR_W-1:0]  region_base;
        logic [IDX_W-1:0]   region_index;
    } in_item_t;

    // Result beat payload, first field in the lowest bits.
    typedef struct packed {
        logic [1:0]        pad;
        logic [ADDR_W-1:0] meta_4k_addr;
        logic [ADDR_W-1:0] meta_2m_addr;
        logic [ADDR_W-1:0] meta_1g_addr;
        status_t           status;
    } out_item_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_HIT_RD,
        S_CHK1,
        S_CHK2,
        S_ADDR,
        S_RESP
    } state_t;

    typedef struct packed {
        logic accept_wr;
        logic accept_lk;
        logic scan;
        logic hit_rd;
        logic chk1;
        logic chk2;
        logic addr;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic scan_done;
        logic found;
        logic out_free;
    } stat_t;

endpackage

[hdl/mrml_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module mrml_ram #(
    parameter int WIDTH = 52,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hdl/mrml_ctrl.sv]
// ----------------------------------------------------------------------------
// Locator controller
// Sequences table writes, the region scan, the checks and the result hand-off.
// ----------------------------------------------------------------------------
module mrml_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    input  logic            s_tuser,
    output logic            s_tready,
    input  mrml_pkg::stat_t stat,
    output mrml_pkg::cmd_t  cmd
);
    import mrml_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    if (s_tuser) begin
                        cmd.accept_lk = 1'b1;
                        state_next    = S_SCAN;
                    end else begin
                        cmd.accept_wr = 1'b1;
                        state_next    = S_RESP;
                    end
                end
            end
            S_SCAN: begin
                cmd.scan = 1'b1;
                if (stat.scan_done) begin
                    state_next = stat.found ? S_HIT_RD : S_RESP;
                end
            end
            S_HIT_RD: begin
                cmd.hit_rd = 1'b1;
                state_next = S_CHK1;
            end
            S_CHK1: begin
                cmd.chk1   = 1'b1;
                state_next = S_CHK2;
            end
            S_CHK2: begin
                cmd.chk2   = 1'b1;
                state_next = S_ADDR;
            end
            S_ADDR: begin
                cmd.addr   = 1'b1;
                state_next = S_RESP;
            end
            S_RESP: begin
                if (stat.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

[hdl/mrml_dpath.sv]
// ----------------------------------------------------------------------------
// Locator datapath
// Region table memories, scan pointer, range checks, address arithmetic and
// the result register.
// ----------------------------------------------------------------------------
module mrml_dpath #(
    parameter int MAX_REGIONS = 64,
    parameter int ENTRY_BYTES = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  mrml_pkg::in_item_t    s_tdata,
    input  logic                  cfg_valid,
    input  logic [6:0]            cfg_data,
    input  mrml_pkg::cmd_t        cmd,
    output mrml_pkg::stat_t       stat,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output mrml_pkg::out_item_t   m_tdata
);
    import mrml_pkg::*;

    localparam int AW     = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
    localparam int CW     = $clog2(MAX_REGIONS + 1);
    localparam int STEP_W = BLOCK_W + $clog2(ENTRY_BYTES + 1);
    localparam int DET_W  = 5 * ADDR_W + LIMIT_W;

    typedef struct packed {
        logic [LIMIT_W-1:0] block_limit;
        logic [ADDR_W-1:0]  meta_4k;
        logic [ADDR_W-1:0]  meta_2m;
        logic [ADDR_W-1:0]  meta_1g;
        logic [ADDR_W-1:0]  init_end;
        logic [ADDR_W-1:0]  size;
    } detail_t;

    // Control state.
    logic [CNT_W-1:0]  regions_reg;
    logic [CW-1:0]     rd_idx_reg, rd_idx_next;
    logic [CW-1:0]     count_reg, count_next;
    logic              pend_reg, pend_next;
    logic [AW-1:0]     pend_idx_reg, pend_idx_next;
    logic              found_reg, found_next;
    logic [AW-1:0]     hit_reg, hit_next;
    logic              m_tvalid_reg;

    // Payload.
    logic [ADDR_W-1:0] pa_reg, pa_next;
    logic              not_cover_reg, not_cover_next;
    logic              not_init_reg, not_init_next;
    logic [BLOCK_W-1:0] block_reg, block_next;
    logic [STEP_W-1:0] step_reg, step_next;
    status_t           status_reg, status_next;
    logic [ADDR_W-1:0] a1g_reg, a1g_next;
    logic [ADDR_W-1:0] a2m_reg, a2m_next;
    logic [ADDR_W-1:0] a4k_reg, a4k_next;
    out_item_t         m_tdata_reg;

    // Memory ports.
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic              base_re;
    logic [AW-1:0]     base_raddr;
    logic [ADDR_W-1:0] base_rd;
    detail_t           det_wr;
    logic [DET_W-1:0]  det_rd_bits;
    detail_t           det_rd;

    logic              issue;
    logic              base_le;
    logic              stop;
    logic [ADDR_W:0]   region_end;
    logic [ADDR_W-1:0] offset;
    logic [ADDR_W-1:0] init_floor;
    logic [ADDR_W-1:0] step_ext;

    assign wr_en   = cmd.accept_wr && (32'(s_tdata.region_index) < MAX_REGIONS);
    assign wr_addr = AW'(s_tdata.region_index);

    assign det_wr.block_limit = s_tdata.block_limit;
    assign det_wr.meta_4k     = s_tdata.meta_4k_base;
    assign det_wr.meta_2m     = s_tdata.meta_2m_base;
    assign det_wr.meta_1g     = s_tdata.meta_1g_base;
    assign det_wr.init_end    = s_tdata.region_init_end;
    assign det_wr.size        = s_tdata.region_size;
    assign det_rd             = detail_t'(det_rd_bits);

    assign base_re    = (cmd.scan && issue) || cmd.hit_rd;
    assign base_raddr = cmd.hit_rd ? hit_reg : rd_idx_reg[AW-1:0];

    mrml_ram #(.WIDTH(ADDR_W), .DEPTH(MAX_REGIONS)) u_base_ram (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (s_tdata.region_base),
        .re    (base_re),
        .raddr (base_raddr),
        .rdata (base_rd)
    );

    mrml_ram #(.WIDTH(DET_W), .DEPTH(MAX_REGIONS)) u_detail_ram (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (DET_W'(det_wr)),
        .re    (cmd.hit_rd),
        .raddr (hit_reg),
        .rdata (det_rd_bits)
    );

    // The scan issues one read per cycle and compares the entry read in the
    // previous cycle, so the compare trails the pointer by one.
    assign issue   = rd_idx_reg < count_reg;
    assign base_le = base_rd <= pa_reg;
    assign stop    = pend_reg && !base_le;

    assign stat.scan_done = stop || (!pend_reg && !issue);
    assign stat.found     = found_reg;
    assign stat.out_free  = !m_tvalid_reg || m_tready;

    assign region_end = {1'b0, base_rd} + {1'b0, det_rd.size};
    assign offset     = pa_reg - base_rd;
    assign init_floor = {det_rd.init_end[ADDR_W-1:GB_SHIFT], GB_SHIFT'(0)};
    assign step_ext   = ADDR_W'(step_reg);

    always_comb begin
        rd_idx_next    = rd_idx_reg;
        count_next     = count_reg;
        pend_next      = pend_reg;
        pend_idx_next  = pend_idx_reg;
        found_next     = found_reg;
        hit_next       = hit_reg;
        pa_next        = pa_reg;
        not_cover_next = not_cover_reg;
        not_init_next  = not_init_reg;
        block_next     = block_reg;
        step_next      = step_reg;
        status_next    = status_reg;
        a1g_next       = a1g_reg;
        a2m_next       = a2m_reg;
        a4k_next       = a4k_reg;

        if (cmd.accept_wr || cmd.accept_lk) begin
            status_next = ST_OK;
            a1g_next    = '0;
            a2m_next    = '0;
            a4k_next    = '0;
        end

        if (cmd.accept_lk) begin
            pa_next     = s_tdata.phys_addr;
            rd_idx_next = '0;
            pend_next   = 1'b0;
            found_next  = 1'b0;
            count_next  = (32'(regions_reg) > MAX_REGIONS) ? CW'(MAX_REGIONS)
                                                           : CW'(regions_reg);
        end

        if (cmd.scan) begin
            if (pend_reg && base_le) begin
                found_next = 1'b1;
                hit_next   = pend_idx_reg;
            end
            pend_next     = issue && !stop;
            pend_idx_next = rd_idx_reg[AW-1:0];
            if (issue) begin
                rd_idx_next = rd_idx_reg + CW'(1);
            end
            if (stat.scan_done && !found_reg) begin
                status_next = ST_NO_REGION;
            end
        end

        if (cmd.chk1) begin
            not_cover_next = {1'b0, pa_reg} >= region_end;
            block_next     = offset[ADDR_W-1:GB_SHIFT];
            not_init_next  = pa_reg >= init_floor;
        end

        if (cmd.chk2) begin
            step_next = STEP_W'(block_reg) * STEP_W'(ENTRY_BYTES);
            if (not_cover_reg) begin
                status_next = ST_NO_REGION;
            end else if ({1'b0, block_reg} >= det_rd.block_limit) begin
                status_next = ST_BLOCK_RANGE;
            end else if (not_init_reg) begin
                status_next = ST_NOT_INIT;
            end else begin
                status_next = ST_OK;
            end
        end

        if (cmd.addr && status_reg == ST_OK) begin
            a1g_next = det_rd.meta_1g + step_ext;
            a2m_next = det_rd.meta_2m + (step_ext << SUB_2M_SHIFT);
            a4k_next = det_rd.meta_4k + (step_ext << SUB_4K_SHIFT);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            regions_reg  <= '0;
            rd_idx_reg   <= '0;
            count_reg    <= '0;
            pend_reg     <= 1'b0;
            found_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                regions_reg <= cfg_data;
            end
            rd_idx_reg <= rd_idx_next;
            count_reg  <= count_next;
            pend_reg   <= pend_next;
            found_reg  <= found_next;
            if (cmd.load_out) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        pend_idx_reg  <= pend_idx_next;
        hit_reg       <= hit_next;
        pa_reg        <= pa_next;
        not_cover_reg <= not_cover_next;
        not_init_reg  <= not_init_next;
        block_reg     <= block_next;
        step_reg      <= step_next;
        status_reg    <= status_next;
        a1g_reg       <= a1g_next;
        a2m_reg       <= a2m_next;
        a4k_reg       <= a4k_next;
        if (cmd.load_out) begin
            m_tdata_reg.pad          <= '0;
            m_tdata_reg.status       <= status_reg;
            m_tdata_reg.meta_1g_addr <= a1g_reg;
            m_tdata_reg.meta_2m_addr <= a2m_reg;
            m_tdata_reg.meta_4k_addr <= a4k_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

[hdl/memory_region_metadata_locator_unit.sv]
// ----------------------------------------------------------------------------
// Memory region metadata locator unit
// Region table with ordered scan that maps a physical address to the 1 GB,
// 2 MB and 4 KB metadata entry addresses of its region.
// ----------------------------------------------------------------------------
// Usage. Items arrive on the s_ stream; s_tuser selects the kind of item: a
// low value writes the table entry named by region_index, a high value looks
// up phys_addr. Every item yields exactly one result beat on the m_ stream,
// carrying a status code and three metadata addresses (zero unless the lookup
// succeeded). The count of entries searched is set through the cfg_ channel,
// which is always ready and must only be written while the block is idle.
// Sequencing. The block works on one item at a time. After a write is
// accepted it passes through the hand-off and back to idle before the next
// item can be taken. A lookup reads the base memory one entry per cycle with
// the compare trailing the reads until the scan closes, then reads the hit
// entry, runs two check steps and an address step, hands off the result and
// returns to idle. The result beat appears on m_ in the cycle after the
// hand-off. The result sits in its own output register, so a stalled
// receiver holds only that beat; the block waits before handing over a
// further result until the register is free.
// Reset clears the controller, the output valid and the region count; the
// table contents are not cleared and entries must be written before use.
// ----------------------------------------------------------------------------
module memory_region_metadata_locator_unit #(
    parameter int MAX_REGIONS = 64,
    parameter int ENTRY_BYTES = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // Input beats.
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // s_tdata, from bit 0: region_index, region_base, region_size,
    // region_init_end, meta_1g_base, meta_2m_base, meta_4k_base,
    // block_limit, phys_addr, zero padding to 400 bits.
    input  mrml_pkg::in_item_t   s_tdata,
    // s_tuser: action (0 table write, 1 lookup).
    input  logic                 s_tuser,
    // Result beats.
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // m_tdata, from bit 0: status, meta_1g_addr, meta_2m_addr, meta_4k_addr,
    // zero padding to 160 bits.
    output mrml_pkg::out_item_t  m_tdata,
    // Region count register.
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [6:0]           cfg_data
);
    import mrml_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    // The count register accepts a write in any cycle.
    assign cfg_ready = 1'b1;

    mrml_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    mrml_dpath #(
        .MAX_REGIONS (MAX_REGIONS),
        .ENTRY_BYTES (ENTRY_BYTES)
    ) u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // A result is only handed over when the output register can take it.
    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> stat.out_free)
        else $error("result loaded over an untaken beat");

    // Once an item is accepted the input is not ready in the following cycle.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while an item is in progress");

    // A failed lookup never reports a metadata address.
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata.status != ST_OK) |->
            (m_tdata.meta_1g_addr == '0 && m_tdata.meta_2m_addr == '0 &&
             m_tdata.meta_4k_addr == '0))
        else $error("non-zero address on a failed lookup");

    // A table write is handed over in the next cycle unless the output
    // register is still holding an untaken beat.
    a_write_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.accept_wr |=> cmd.load_out || !stat.out_free)
        else $error("write item not answered directly");

endmodule

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// Memory region metadata locator unit testbench
// Loads region tables, points lookups at the interesting parts of each region
// and checks every result beat against an in-bench prediction of the unit.
// A short directed sequence comes first, then randomised table loads with
// lookups aimed at region edges, block counts and initialisation limits.
// ----------------------------------------------------------------------------
module testbench;

    import mrml_pkg::*;

    localparam int          MAX_ENTRIES      = 64;
    localparam int          MD_ENTRY_BYTES   = 16;
    localparam int          RANDOM_ITEMS     = 1850;
    localparam int          LONG_HOLD_CYCLES = 700;
    localparam int          DRAIN_CYCLES     = 100;
    localparam int          PRINT_CAP        = 40;
    localparam int unsigned CYCLE_LIMIT      = 1_500_000;
    localparam int unsigned LIMIT_TOP        = 4194304;
    localparam logic [ADDR_W-1:0] ONE_GB     = 52'h0_0000_4000_0000;
    localparam logic [ADDR_W-1:0] ADDR_TOP   = {ADDR_W{1'b1}};
    localparam logic [31:0]       LOW_MASK   = 32'h3FFF_FFFF;

    // The kind of item carried on s_tuser.
    typedef enum logic {
        ACT_WRITE  = 1'b0,
        ACT_LOOKUP = 1'b1
    } action_t;

    // One row of the directed sequence.
    typedef enum logic [1:0] {
        ROW_COUNT,
        ROW_WRITE,
        ROW_LOOKUP
    } row_kind_t;

    typedef struct {
        row_kind_t  kind;
        logic [6:0] count;
        in_item_t   item;
        logic       typed;
        status_t    status;
    } step_row_t;

    // Our own copy of one region table entry.
    typedef struct {
        logic [ADDR_W-1:0]  base;
        logic [ADDR_W-1:0]  size;
        logic [ADDR_W-1:0]  init_end;
        logic [ADDR_W-1:0]  meta_1g;
        logic [ADDR_W-1:0]  meta_2m;
        logic [ADDR_W-1:0]  meta_4k;
        logic [LIMIT_W-1:0] blocks;
    } region_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    in_item_t    s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    out_item_t   m_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [6:0]  cfg_data;

    // Predicted state of the unit, updated as each beat is accepted.
    region_t     region_table [MAX_ENTRIES];
    logic [6:0]  regions_in_use;

    // Results owed by the unit, oldest first.
    out_item_t   pending_answers [$];

    int          mismatch_count;
    int          answer_beats;
    int          burst_left;
    int          hold_requests;

    memory_region_metadata_locator_unit #(
        .MAX_REGIONS (MAX_ENTRIES),
        .ENTRY_BYTES (MD_ENTRY_BYTES)
    ) u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // Prediction. A table write stores the entry and answers with a clean OK.
    // A lookup walks the entries in use, keeps the last one whose base is not
    // above the address and stops at the first that is. The checks then run
    // in a fixed order: the region must cover the address (its end is taken
    // without wrapping), the 1 GB block number must be below the entry's
    // count, and the address must lie below the initialised end rounded down
    // to 1 GB. The three metadata addresses wrap at 52 bits.
    // ------------------------------------------------------------------------
    function automatic out_item_t locate_metadata(input in_item_t d, input action_t act);
        out_item_t         res;
        region_t           hit_entry;
        int                count;
        int                hit;
        bit                found;
        logic [ADDR_W:0]   region_end;
        logic [ADDR_W-1:0] block;
        res = '0;
        res.status = ST_OK;
        if (act == ACT_WRITE) begin
            region_table[d.region_index].base     = d.region_base;
            region_table[d.region_index].size     = d.region_size;
            region_table[d.region_index].init_end = d.region_init_end;
            region_table[d.region_index].meta_1g  = d.meta_1g_base;
            region_table[d.region_index].meta_2m  = d.meta_2m_base;
            region_table[d.region_index].meta_4k  = d.meta_4k_base;
            region_table[d.region_index].blocks   = d.block_limit;
            return res;
        end
        count = (regions_in_use > MAX_ENTRIES) ? MAX_ENTRIES : int'(regions_in_use);
        found = 1'b0;
        hit   = 0;
        for (int i = 0; i < count; i++) begin
            if (region_table[i].base <= d.phys_addr) begin
                found = 1'b1;
                hit   = i;
            end else begin
                break;
            end
        end
        if (!found) begin
            res.status = ST_NO_REGION;
            return res;
        end
        hit_entry  = region_table[hit];
        region_end = {1'b0, hit_entry.base} + {1'b0, hit_entry.size};
        if ({1'b0, d.phys_addr} >= region_end) begin
            res.status = ST_NO_REGION;
            return res;
        end
        block = (d.phys_addr - hit_entry.base) >> GB_SHIFT;
        if (block >= hit_entry.blocks) begin
            res.status = ST_BLOCK_RANGE;
            return res;
        end
        if (d.phys_addr >= {hit_entry.init_end[ADDR_W-1:GB_SHIFT], {GB_SHIFT{1'b0}}}) begin
            res.status = ST_NOT_INIT;
            return res;
        end
        res.meta_1g_addr = hit_entry.meta_1g + block * MD_ENTRY_BYTES;
        res.meta_2m_addr = hit_entry.meta_2m + ((block * MD_ENTRY_BYTES) << SUB_2M_SHIFT);
        res.meta_4k_addr = hit_entry.meta_4k + ((block * MD_ENTRY_BYTES) << SUB_4K_SHIFT);
        return res;
    endfunction

    function automatic logic [ADDR_W-1:0] rand_addr();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[ADDR_W-1:0];
    endfunction

    // Every field filled at random; callers then overwrite what matters.
    function automatic in_item_t random_payload();
        in_item_t d;
        d.pad             = '0;
        d.region_index    = IDX_W'($urandom_range(0, MAX_ENTRIES - 1));
        d.region_base     = rand_addr();
        d.region_size     = rand_addr();
        d.region_init_end = rand_addr();
        d.meta_1g_base    = rand_addr();
        d.meta_2m_base    = rand_addr();
        d.meta_4k_base    = rand_addr();
        d.block_limit     = LIMIT_W'($urandom_range(0, LIMIT_TOP));
        d.phys_addr       = rand_addr();
        return d;
    endfunction

    function automatic step_row_t count_step(input logic [6:0] value);
        step_row_t row;
        row.kind   = ROW_COUNT;
        row.count  = value;
        row.item   = '0;
        row.typed  = 1'b0;
        row.status = ST_OK;
        return row;
    endfunction

    // A table write always answers OK with zero addresses.
    function automatic step_row_t write_step(
        input logic [IDX_W-1:0]   idx,
        input logic [ADDR_W-1:0]  base,
        input logic [ADDR_W-1:0]  size,
        input logic [ADDR_W-1:0]  init_end,
        input logic [ADDR_W-1:0]  m1g,
        input logic [ADDR_W-1:0]  m2m,
        input logic [ADDR_W-1:0]  m4k,
        input logic [LIMIT_W-1:0] blocks
    );
        step_row_t row;
        row.kind                 = ROW_WRITE;
        row.count                = '0;
        row.item                 = random_payload();
        row.item.region_index    = idx;
        row.item.region_base     = base;
        row.item.region_size     = size;
        row.item.region_init_end = init_end;
        row.item.meta_1g_base    = m1g;
        row.item.meta_2m_base    = m2m;
        row.item.meta_4k_base    = m4k;
        row.item.block_limit     = blocks;
        row.typed                = 1'b1;
        row.status               = ST_OK;
        return row;
    endfunction

    function automatic step_row_t lookup_step(
        input logic [ADDR_W-1:0] pa,
        input logic              typed,
        input status_t           status
    );
        step_row_t row;
        row.kind           = ROW_LOOKUP;
        row.count          = '0;
        row.item           = random_payload();
        row.item.phys_addr = pa;
        row.typed          = typed;
        row.status         = status;
        return row;
    endfunction

    task automatic flag_mismatch(
        input string             what,
        input logic [ADDR_W-1:0] got,
        input logic [ADDR_W-1:0] want
    );
        mismatch_count++;
        if (mismatch_count <= PRINT_CAP)
            $display("[%0t] result beat %0d: %s is %h, predicted %h",
                     $time, answer_beats, what, got, want);
    endtask

    // ------------------------------------------------------------------------
    // Sender. Items go out in bursts of random length; between bursts the
    // valid is dropped for a random gap, occasionally long enough to cover a
    // full 64-entry scan so that gaps land on every stage of a lookup. The
    // prediction is taken at the edge where the beat is accepted, so a typed
    // answer from the directed rows replaces it but the table still updates.
    // ------------------------------------------------------------------------
    task automatic offer(
        input in_item_t d,
        input action_t  act,
        input logic     typed,
        input status_t  status
    );
        int        gap;
        out_item_t answer;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            case ($urandom_range(0, 7))
                0, 1:    gap = 0;
                2:       gap = $urandom_range(20, 90);
                default: gap = $urandom_range(1, 6);
            endcase
            repeat (gap) begin
                @(negedge aclk);
                s_tvalid <= 1'b0;
            end
        end
        burst_left--;
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tuser  <= act;
        do @(posedge aclk); while (!s_tready);
        answer = locate_metadata(d, act);
        if (typed) begin
            answer = '0;
            answer.status = status;
        end
        pending_answers.push_back(answer);
    endtask

    // The region count may only change while the unit is idle: the input is
    // withdrawn and every owed result must have come back first.
    task automatic write_region_count(input logic [6:0] value);
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        regions_in_use = value;
        @(negedge aclk);
        cfg_valid  <= 1'b0;
        burst_left = 0;
    endtask

    // ------------------------------------------------------------------------
    // Main sequence: reset, directed rows, then randomised phases. Each phase
    // loads a sorted run of regions from a random point in the address space,
    // sets how many of them a lookup searches, and fires lookups mostly aimed
    // at region starts, ends, block boundaries and initialisation limits,
    // with some wild addresses and stray writes above the searched entries.
    // ------------------------------------------------------------------------
    initial begin : stimulus
        step_row_t         directed_steps [$];
        step_row_t         row;
        in_item_t          d;
        region_t           target;
        int                span_gb [MAX_ENTRIES];
        int                random_items;
        int                phase_no;
        int                n;
        int                k;
        int                j;
        int                gb;
        logic [63:0]       cursor;
        logic [ADDR_W-1:0] pa;

        aresetn        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = ACT_WRITE;
        cfg_valid      = 1'b0;
        cfg_data       = '0;
        regions_in_use = '0;
        mismatch_count = 0;
        answer_beats   = 0;
        burst_left     = 0;
        hold_requests  = 0;
        random_items   = 0;
        phase_no       = 0;

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Nothing is searched straight after reset.
        directed_steps.push_back(lookup_step('0, 1'b1, ST_NO_REGION));
        directed_steps.push_back(lookup_step(ADDR_TOP, 1'b1, ST_NO_REGION));
        // Region at zero: 16 GB, ten blocks, initialised up to just past 8 GB.
        directed_steps.push_back(write_step(6'd0, '0, 16 * ONE_GB,
                                            8 * ONE_GB + 52'h1234, '0,
                                            52'h0_0ABC_DEF0_1234, ADDR_TOP, 23'd10));
        // Region at the top of the space whose end overruns 52 bits, with
        // metadata bases that wrap.
        directed_steps.push_back(write_step(6'd1, ADDR_TOP - 3 * ONE_GB + 1, ADDR_TOP,
                                            ADDR_TOP, ADDR_TOP, ADDR_TOP, ADDR_TOP,
                                            23'd2));
        // Highest index with the largest block count, never searched here.
        directed_steps.push_back(write_step(6'd63, ADDR_TOP, '0, '0, '0, '0, '0,
                                            LIMIT_W'(LIMIT_TOP)));
        directed_steps.push_back(count_step(7'd2));
        directed_steps.push_back(lookup_step('0, 1'b0, ST_OK));
        directed_steps.push_back(lookup_step(3 * ONE_GB + 52'h155, 1'b0, ST_OK));
        directed_steps.push_back(lookup_step(8 * ONE_GB, 1'b1, ST_NOT_INIT));
        // Block count fails before the initialisation check.
        directed_steps.push_back(lookup_step(10 * ONE_GB, 1'b1, ST_BLOCK_RANGE));
        // Coverage fails before the block count check.
        directed_steps.push_back(lookup_step(16 * ONE_GB, 1'b1, ST_NO_REGION));
        directed_steps.push_back(lookup_step(16 * ONE_GB - 1, 1'b1, ST_BLOCK_RANGE));
        directed_steps.push_back(lookup_step(ADDR_TOP - ONE_GB, 1'b0, ST_OK));
        directed_steps.push_back(lookup_step(ADDR_TOP, 1'b1, ST_BLOCK_RANGE));
        directed_steps.push_back(lookup_step(ADDR_TOP - 3 * ONE_GB, 1'b1, ST_NO_REGION));
        // With one entry searched the top region is out of reach.
        directed_steps.push_back(count_step(7'd1));
        directed_steps.push_back(lookup_step(ADDR_TOP, 1'b1, ST_NO_REGION));
        // First base above the address: no region at all.
        directed_steps.push_back(write_step(6'd0, 5 * ONE_GB, 2 * ONE_GB, ADDR_TOP,
                                            52'h0_0000_0000_0100, '0,
                                            52'h8_0000_0000_0000, 23'd1));
        directed_steps.push_back(lookup_step('0, 1'b1, ST_NO_REGION));
        directed_steps.push_back(lookup_step(5 * ONE_GB + 1, 1'b0, ST_OK));
        directed_steps.push_back(lookup_step(6 * ONE_GB, 1'b1, ST_BLOCK_RANGE));
        directed_steps.push_back(count_step(7'd0));
        directed_steps.push_back(lookup_step(5 * ONE_GB + 1, 1'b1, ST_NO_REGION));

        foreach (directed_steps[i]) begin
            row = directed_steps[i];
            case (row.kind)
                ROW_COUNT:  write_region_count(row.count);
                ROW_WRITE:  offer(row.item, ACT_WRITE, row.typed, row.status);
                default:    offer(row.item, ACT_LOOKUP, row.typed, row.status);
            endcase
        end

        while (random_items < RANDOM_ITEMS) begin
            // The first two phases fill the whole table so that the full
            // search depth is exercised early.
            if (phase_no < 2 || $urandom_range(0, 7) == 0)
                n = MAX_ENTRIES;
            else
                n = $urandom_range(1, 12);
            cursor = {12'd0, rand_addr()};
            if (cursor > ({12'd0, ADDR_TOP} - (64'd1 << 41)))
                cursor = cursor - (64'd1 << 41);

            for (j = 0; j < n; j++) begin
                gb         = $urandom_range(0, 8);
                span_gb[j] = gb;
                if ($urandom_range(0, 5) != 0)
                    cursor = cursor + ONE_GB * $urandom_range(0, 3) + ($urandom & LOW_MASK);
                d              = random_payload();
                d.region_index = IDX_W'(j);
                d.region_base  = cursor[ADDR_W-1:0];
                if ($urandom_range(0, 9) == 0)
                    d.region_size = rand_addr();
                else if ($urandom_range(0, 3) == 0)
                    d.region_size = ONE_GB * gb;
                else
                    d.region_size = ONE_GB * gb + ($urandom & LOW_MASK);
                if ($urandom_range(0, 9) != 0)
                    d.region_init_end = d.region_base + ONE_GB * $urandom_range(0, gb + 1)
                                        + ($urandom & LOW_MASK);
                if ($urandom_range(0, 7) != 0)
                    d.block_limit = LIMIT_W'($urandom_range(0, gb + 1));
                cursor = cursor + ONE_GB * gb;
                offer(d, ACT_WRITE, 1'b0, ST_OK);
                random_items++;
            end

            case ($urandom_range(0, 5))
                0:       k = 0;
                1:       k = n;
                default: k = $urandom_range(1, n);
            endcase
            if (phase_no == 0)
                k = MAX_ENTRIES;
            write_region_count(7'(k));

            // Twice in the run the receiver holds off for a long stretch
            // while lookups keep coming, so the unit backs up to its input.
            if (phase_no == 2 || phase_no == 9)
                hold_requests++;

            repeat ($urandom_range(30, 80)) begin
                d = random_payload();
                case ($urandom_range(0, 9))
                    7: begin
                        offer(d, ACT_LOOKUP, 1'b0, ST_OK);
                    end
                    8, 9: begin
                        // Stray write above the searched entries.
                        if (k < MAX_ENTRIES) begin
                            d.region_index = IDX_W'($urandom_range(k, MAX_ENTRIES - 1));
                            offer(d, ACT_WRITE, 1'b0, ST_OK);
                        end else begin
                            offer(d, ACT_LOOKUP, 1'b0, ST_OK);
                        end
                    end
                    default: begin
                        if (k > 0) begin
                            j      = $urandom_range(0, k - 1);
                            target = region_table[j];
                            case ($urandom_range(0, 5))
                                0: pa = target.base;
                                1: pa = target.base - 1;
                                2: pa = {target.init_end[ADDR_W-1:GB_SHIFT],
                                         {GB_SHIFT{1'b0}}} - $urandom_range(0, 1);
                                3: pa = target.base + target.size - $urandom_range(0, 1);
                                default: pa = target.base
                                              + ONE_GB * $urandom_range(0, span_gb[j] + 1)
                                              + ($urandom & LOW_MASK);
                            endcase
                            d.phys_addr = pa;
                        end
                        offer(d, ACT_LOOKUP, 1'b0, ST_OK);
                    end
                endcase
                random_items++;
            end
            phase_no++;
        end

        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge aclk);
        // A little longer, so that any stray extra beat is caught too.
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Receiver. Its readiness follows a pattern of its own that rotates between
    // always ready, mostly ready, a fixed duty cycle and a coin toss. A long
    // hold-off is granted whenever the main sequence asks.
    // ------------------------------------------------------------------------
    initial begin : result_sink
        int tick;
        int hold_left;
        int holds_granted;
        tick          = 0;
        hold_left     = 0;
        holds_granted = 0;
        m_tready      = 1'b0;
        forever begin
            @(negedge aclk);
            tick++;
            if (hold_left == 0 && holds_granted < hold_requests) begin
                holds_granted++;
                hold_left = LONG_HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                case ((tick >> 8) % 4)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= ($urandom_range(0, 3) != 0);
                    2:       m_tready <= ((tick % 13) >= 5);
                    default: m_tready <= 1'($urandom_range(0, 1));
                endcase
            end
        end
    end

    // Every accepted result beat is matched against the oldest owed answer.
    initial begin : answer_check
        out_item_t want;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                answer_beats++;
                if (pending_answers.size() == 0) begin
                    flag_mismatch("unrequested beat status", ADDR_W'(m_tdata.status), '0);
                end else begin
                    want = pending_answers.pop_front();
                    if (m_tdata.status !== want.status)
                        flag_mismatch("status", ADDR_W'(m_tdata.status),
                                      ADDR_W'(want.status));
                    if (m_tdata.meta_1g_addr !== want.meta_1g_addr)
                        flag_mismatch("meta_1g_addr", m_tdata.meta_1g_addr,
                                      want.meta_1g_addr);
                    if (m_tdata.meta_2m_addr !== want.meta_2m_addr)
                        flag_mismatch("meta_2m_addr", m_tdata.meta_2m_addr,
                                      want.meta_2m_addr);
                    if (m_tdata.meta_4k_addr !== want.meta_4k_addr)
                        flag_mismatch("meta_4k_addr", m_tdata.meta_4k_addr,
                                      want.meta_4k_addr);
                end
            end
        end
    end

    // Run limit, far above the slowest correct run.
    initial begin : watchdog
        int unsigned cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Mismatches found");
        $finish;
    end

endmodule
